@@ rtl/rthsv_pkg.sv @@
package rthsv_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W = 13;
  localparam int unsigned PCT_W = 15;

  localparam int unsigned HUE_NUM_W = 21;
  localparam int unsigned HUE_REC_W = 22;
  localparam int unsigned PCT_NUM_W = 23;
  localparam int unsigned PCT_REC_W = 24;

  localparam int unsigned HUE_SECTOR = 960;
  localparam int unsigned HUE_FULL = 5760;
  localparam int unsigned PCT_SCALE = 25600;
  localparam int unsigned CHAN_MAX = 255;

  localparam logic [PCT_REC_W-1:0] VAL_REC = PCT_REC_W'((1 << PCT_NUM_W) / CHAN_MAX);

  // Sector code times two sectors of hue gives the base offset in units of delta.
  typedef enum logic [1:0] {
    SEC_RED_UP   = 2'd0,
    SEC_GREEN    = 2'd1,
    SEC_BLUE     = 2'd2,
    SEC_RED_DOWN = 2'd3
  } sector_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

@@ rtl/rgb_to_hsv_convert.sv @@
// A word accepted at the input is registered in each stage in turn before valid_o shows it.
// Throughput: one word per cycle with no stall; four register stages
// (extrema, numerators, reciprocal multiply, remainder correction).
// A stall holds the full stages from the output back to the first empty one; an empty stage still takes new data.
// Reset clears the stage valid bits asynchronously; data registers keep no reset.
module rgb_to_hsv_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [rthsv_pkg::CHAN_W-1:0]  red_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]  green_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]  blue_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [rthsv_pkg::HUE_W-1:0]   hue_o,
  output logic [rthsv_pkg::PCT_W-1:0]   saturation_o,
  output logic [rthsv_pkg::PCT_W-1:0]   brightness_o
);

  rthsv_pkg::pipe_en_t en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [rthsv_pkg::CHAN_W-1:0] delta1, hi1, delta2, hi2;
  rthsv_pkg::sector_e sector1;
  logic signed [rthsv_pkg::CHAN_W:0] diff1;
  logic [rthsv_pkg::HUE_NUM_W-1:0] hue_num;
  logic [rthsv_pkg::HUE_REC_W-1:0] hue_rec;
  logic [rthsv_pkg::PCT_NUM_W-1:0] sat_num, val_num;
  logic [rthsv_pkg::PCT_REC_W-1:0] sat_rec;

  assign en.s4 = !v4_q || !stall_i;
  assign en.s3 = !v3_q || en.s4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;
  assign stall_o = !en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;

  rthsv_extrema u_extrema (
    .clk_i    (clk_i),
    .en_i     (en),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .delta_o  (delta1),
    .hi_o     (hi1),
    .sector_o (sector1),
    .diff_o   (diff1)
  );

  rthsv_numer u_numer (
    .clk_i     (clk_i),
    .en_i      (en),
    .delta_i   (delta1),
    .hi_i      (hi1),
    .sector_i  (sector1),
    .diff_i    (diff1),
    .hue_num_o (hue_num),
    .hue_rec_o (hue_rec),
    .sat_num_o (sat_num),
    .sat_rec_o (sat_rec),
    .val_num_o (val_num),
    .delta_o   (delta2),
    .hi_o      (hi2)
  );

  rthsv_rdiv #(
    .NUM_W (rthsv_pkg::HUE_NUM_W),
    .REC_W (rthsv_pkg::HUE_REC_W),
    .DEN_W (rthsv_pkg::CHAN_W),
    .Q_W   (rthsv_pkg::HUE_W),
    .SHIFT (rthsv_pkg::HUE_NUM_W)
  ) u_hue_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (hue_num),
    .rec_i  (hue_rec),
    .den_i  (delta2),
    .quot_o (hue_o)
  );

  rthsv_rdiv #(
    .NUM_W (rthsv_pkg::PCT_NUM_W),
    .REC_W (rthsv_pkg::PCT_REC_W),
    .DEN_W (rthsv_pkg::CHAN_W),
    .Q_W   (rthsv_pkg::PCT_W),
    .SHIFT (rthsv_pkg::PCT_NUM_W)
  ) u_sat_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (sat_num),
    .rec_i  (sat_rec),
    .den_i  (hi2),
    .quot_o (saturation_o)
  );

  rthsv_rdiv #(
    .NUM_W (rthsv_pkg::PCT_NUM_W),
    .REC_W (rthsv_pkg::PCT_REC_W),
    .DEN_W (rthsv_pkg::CHAN_W),
    .Q_W   (rthsv_pkg::PCT_W),
    .SHIFT (rthsv_pkg::PCT_NUM_W)
  ) u_val_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (val_num),
    .rec_i  (rthsv_pkg::VAL_REC),
    .den_i  (rthsv_pkg::CHAN_W'(rthsv_pkg::CHAN_MAX)),
    .quot_o (brightness_o)
  );

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("Input stalled while the output stage is empty.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> v1_q)
    else $error("Accepted word did not enter the first stage.");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> hue_o < rthsv_pkg::HUE_W'(rthsv_pkg::HUE_FULL))
    else $error("Hue out of range.");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> saturation_o <= rthsv_pkg::PCT_W'(rthsv_pkg::PCT_SCALE)
             && brightness_o <= rthsv_pkg::PCT_W'(rthsv_pkg::PCT_SCALE))
    else $error("Saturation or value out of range.");

endmodule

@@ rtl/rthsv_extrema.sv @@
module rthsv_extrema (
  input  logic                          clk_i,
  input  rthsv_pkg::pipe_en_t           en_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]  red_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]  green_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]  blue_i,
  output logic [rthsv_pkg::CHAN_W-1:0]  delta_o,
  output logic [rthsv_pkg::CHAN_W-1:0]  hi_o,
  output rthsv_pkg::sector_e            sector_o,
  output logic signed [rthsv_pkg::CHAN_W:0] diff_o
);

  logic [rthsv_pkg::CHAN_W-1:0] hi_d, lo_d, delta_q, hi_q;
  logic signed [rthsv_pkg::CHAN_W:0] diff_d, diff_q;
  rthsv_pkg::sector_e sector_d, sector_q;

  always_comb begin
    hi_d = red_i;
    lo_d = red_i;
    if (green_i > hi_d) hi_d = green_i;
    if (blue_i > hi_d) hi_d = blue_i;
    if (green_i < lo_d) lo_d = green_i;
    if (blue_i < lo_d) lo_d = blue_i;
    priority if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = (green_i >= blue_i) ? rthsv_pkg::SEC_RED_UP : rthsv_pkg::SEC_RED_DOWN;
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sector_d = rthsv_pkg::SEC_GREEN;
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector_d = rthsv_pkg::SEC_BLUE;
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      delta_q <= hi_d - lo_d;
      hi_q <= hi_d;
      sector_q <= sector_d;
      diff_q <= diff_d;
    end
  end

  assign delta_o = delta_q;
  assign hi_o = hi_q;
  assign sector_o = sector_q;
  assign diff_o = diff_q;

endmodule

@@ rtl/rthsv_numer.sv @@
module rthsv_numer (
  input  logic                              clk_i,
  input  rthsv_pkg::pipe_en_t               en_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]      delta_i,
  input  logic [rthsv_pkg::CHAN_W-1:0]      hi_i,
  input  rthsv_pkg::sector_e                sector_i,
  input  logic signed [rthsv_pkg::CHAN_W:0] diff_i,
  output logic [rthsv_pkg::HUE_NUM_W-1:0]   hue_num_o,
  output logic [rthsv_pkg::HUE_REC_W-1:0]   hue_rec_o,
  output logic [rthsv_pkg::PCT_NUM_W-1:0]   sat_num_o,
  output logic [rthsv_pkg::PCT_REC_W-1:0]   sat_rec_o,
  output logic [rthsv_pkg::PCT_NUM_W-1:0]   val_num_o,
  output logic [rthsv_pkg::CHAN_W-1:0]      delta_o,
  output logic [rthsv_pkg::CHAN_W-1:0]      hi_o
);

  localparam int unsigned TAB_N = 1 << rthsv_pkg::CHAN_W;
  localparam int unsigned SUM_W = rthsv_pkg::HUE_NUM_W + 2;

  logic [rthsv_pkg::HUE_REC_W-1:0] hue_rec_tab [TAB_N];
  logic [rthsv_pkg::PCT_REC_W-1:0] sat_rec_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam logic [rthsv_pkg::HUE_REC_W-1:0] HueRec =
      (i == 0) ? '0 : rthsv_pkg::HUE_REC_W'((1 << rthsv_pkg::HUE_NUM_W) / i);
    localparam logic [rthsv_pkg::PCT_REC_W-1:0] SatRec =
      (i == 0) ? '0 : rthsv_pkg::PCT_REC_W'((1 << rthsv_pkg::PCT_NUM_W) / i);
    assign hue_rec_tab[i] = HueRec;
    assign sat_rec_tab[i] = SatRec;
  end

  logic [rthsv_pkg::CHAN_W+1:0] base_mult;
  logic [rthsv_pkg::HUE_NUM_W-1:0] base;
  logic signed [SUM_W-1:0] hue_sum;

  logic [rthsv_pkg::HUE_NUM_W-1:0] hue_num_q;
  logic [rthsv_pkg::HUE_REC_W-1:0] hue_rec_q;
  logic [rthsv_pkg::PCT_NUM_W-1:0] sat_num_q, val_num_q;
  logic [rthsv_pkg::PCT_REC_W-1:0] sat_rec_q;
  logic [rthsv_pkg::CHAN_W-1:0] delta_q, hi_q;

  assign base_mult = {{rthsv_pkg::CHAN_W{1'b0}}, sector_i} * {2'b00, delta_i};
  assign base = rthsv_pkg::HUE_NUM_W'(base_mult)
              * rthsv_pkg::HUE_NUM_W'(2 * rthsv_pkg::HUE_SECTOR);
  assign hue_sum = $signed({2'b00, base})
                 + $signed({{(SUM_W - rthsv_pkg::CHAN_W - 1){diff_i[rthsv_pkg::CHAN_W]}}, diff_i})
                 * $signed(SUM_W'(rthsv_pkg::HUE_SECTOR));

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      hue_num_q <= hue_sum[rthsv_pkg::HUE_NUM_W-1:0];
      hue_rec_q <= hue_rec_tab[delta_i];
      sat_num_q <= rthsv_pkg::PCT_NUM_W'(delta_i) * rthsv_pkg::PCT_NUM_W'(rthsv_pkg::PCT_SCALE);
      sat_rec_q <= sat_rec_tab[hi_i];
      val_num_q <= rthsv_pkg::PCT_NUM_W'(hi_i) * rthsv_pkg::PCT_NUM_W'(rthsv_pkg::PCT_SCALE);
      delta_q <= delta_i;
      hi_q <= hi_i;
    end
  end

  assign hue_num_o = hue_num_q;
  assign hue_rec_o = hue_rec_q;
  assign sat_num_o = sat_num_q;
  assign sat_rec_o = sat_rec_q;
  assign val_num_o = val_num_q;
  assign delta_o = delta_q;
  assign hi_o = hi_q;

endmodule

@@ rtl/rthsv_rdiv.sv @@
module rthsv_rdiv #(
  parameter int unsigned NUM_W = rthsv_pkg::HUE_NUM_W,
  parameter int unsigned REC_W = rthsv_pkg::HUE_REC_W,
  parameter int unsigned DEN_W = rthsv_pkg::CHAN_W,
  parameter int unsigned Q_W = rthsv_pkg::HUE_W,
  parameter int unsigned SHIFT = rthsv_pkg::HUE_NUM_W
) (
  input  logic                clk_i,
  input  rthsv_pkg::pipe_en_t en_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [REC_W-1:0]    rec_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [Q_W-1:0]      quot_o
);

  localparam int unsigned PROD_W = NUM_W + REC_W;

  // The reciprocal estimate is at most one below the exact quotient.
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0] est_q, quot_q;
  logic [NUM_W-1:0] num_q, back, rem;
  logic [DEN_W-1:0] den_q;
  logic bump;

  assign prod = PROD_W'(num_i) * PROD_W'(rec_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      est_q <= Q_W'(prod >> SHIFT);
      num_q <= num_i;
      den_q <= den_i;
    end
  end

  assign back = NUM_W'(NUM_W'(est_q) * NUM_W'(den_q));
  assign rem = num_q - back;
  assign bump = (den_q != '0) && (rem >= NUM_W'(den_q));

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      quot_q <= est_q + Q_W'(bump);
    end
  end

  assign quot_o = quot_q;

endmodule

@@ tb/rgb_to_hsv_convert_tb.sv @@
`timescale 1ns / 100ps

module rgb_to_hsv_convert_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_WORDS = 275;

  typedef struct packed {
    logic [rthsv_pkg::HUE_W-1:0] hue;
    logic [rthsv_pkg::PCT_W-1:0] sat;
    logic [rthsv_pkg::PCT_W-1:0] bright;
  } hsv_t;

  function automatic hsv_t predict_hsv(logic [rthsv_pkg::CHAN_W-1:0] r8,
                                       logic [rthsv_pkg::CHAN_W-1:0] g8,
                                       logic [rthsv_pkg::CHAN_W-1:0] b8);
    int unsigned r, g, b, hi, lo, d, num, h, s, v;
    hsv_t res;
    r = 32'(r8);
    g = 32'(g8);
    b = 32'(b8);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d = hi - lo;
    if (d == 0) begin
      h = 0;
    end else begin
      if (hi == r) begin
        if (g >= b) num = rthsv_pkg::HUE_SECTOR * (g - b);
        else num = rthsv_pkg::HUE_FULL * d - rthsv_pkg::HUE_SECTOR * (b - g);
      end else if (hi == g) begin
        num = 2 * rthsv_pkg::HUE_SECTOR * d + rthsv_pkg::HUE_SECTOR * b
            - rthsv_pkg::HUE_SECTOR * r;
      end else begin
        num = 4 * rthsv_pkg::HUE_SECTOR * d + rthsv_pkg::HUE_SECTOR * r
            - rthsv_pkg::HUE_SECTOR * g;
      end
      h = num / d;
    end
    s = (hi == 0) ? 0 : (rthsv_pkg::PCT_SCALE * d) / hi;
    v = (rthsv_pkg::PCT_SCALE * hi) / rthsv_pkg::CHAN_MAX;
    res.hue = h[rthsv_pkg::HUE_W-1:0];
    res.sat = s[rthsv_pkg::PCT_W-1:0];
    res.bright = v[rthsv_pkg::PCT_W-1:0];
    return res;
  endfunction

  class hsv_scoreboard;
    hsv_t expected_hsv[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endfunction

    function void note_pixel(logic [rthsv_pkg::CHAN_W-1:0] r,
                             logic [rthsv_pkg::CHAN_W-1:0] g,
                             logic [rthsv_pkg::CHAN_W-1:0] b);
      expected_hsv.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_result(logic [rthsv_pkg::HUE_W-1:0] h,
                               logic [rthsv_pkg::PCT_W-1:0] s,
                               logic [rthsv_pkg::PCT_W-1:0] v);
      hsv_t exp_w;
      if (expected_hsv.size() == 0) begin
        report_mismatch($sformatf("unexpected word hue=%0d sat=%0d bright=%0d", h, s, v));
        return;
      end
      exp_w = expected_hsv.pop_front();
      if (h !== exp_w.hue)
        report_mismatch($sformatf("hue got %0d expected %0d", h, exp_w.hue));
      if (s !== exp_w.sat)
        report_mismatch($sformatf("saturation got %0d expected %0d", s, exp_w.sat));
      if (v !== exp_w.bright)
        report_mismatch($sformatf("brightness got %0d expected %0d", v, exp_w.bright));
    endfunction

    function int unsigned pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [rthsv_pkg::CHAN_W-1:0] red_i = '0;
  logic [rthsv_pkg::CHAN_W-1:0] green_i = '0;
  logic [rthsv_pkg::CHAN_W-1:0] blue_i = '0;
  logic stall_o;
  logic valid_o;
  logic [rthsv_pkg::HUE_W-1:0] hue_o;
  logic [rthsv_pkg::PCT_W-1:0] saturation_o;
  logic [rthsv_pkg::PCT_W-1:0] brightness_o;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  hsv_scoreboard sb = new();

  rgb_to_hsv_convert dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .red_i(red_i),
    .green_i(green_i),
    .blue_i(blue_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .hue_o(hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) sb.note_pixel(red_i, green_i, blue_i);
      if (valid_o && !stall_i) sb.check_result(hue_o, saturation_o, brightness_o);
    end
  end

  task automatic send_pixel(logic [rthsv_pkg::CHAN_W-1:0] r,
                            logic [rthsv_pkg::CHAN_W-1:0] g,
                            logic [rthsv_pkg::CHAN_W-1:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (!(valid_i && !stall_o));
  endtask

  task automatic send_random_pixel();
    logic [rthsv_pkg::CHAN_W-1:0] r, g, b;
    int unsigned mode;
    r = rthsv_pkg::CHAN_W'($urandom());
    g = rthsv_pkg::CHAN_W'($urandom());
    b = rthsv_pkg::CHAN_W'($urandom());
    mode = $urandom_range(0, 9);
    case (mode)
      6: begin
        g = r;
        b = r;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      8: begin
        r = rthsv_pkg::CHAN_W'($urandom_range(0, 3));
        g = rthsv_pkg::CHAN_W'($urandom_range(0, 3));
        b = rthsv_pkg::CHAN_W'($urandom_range(0, 3));
      end
      9: begin
        case ($urandom_range(0, 2))
          0: r = '1;
          1: g = '1;
          default: b = '1;
        endcase
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd100, 8'd10);
    send_pixel(8'd200, 8'd10, 8'd100);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd10, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd10, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd85);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          sender_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) send_random_pixel();
    end

    valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("words still expected at end of run");

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
